// ===== rtl/rcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrs_pkg
// Types and constants shared by the column ray setup core.
// ----------------------------------------------------------------------------
package rcrs_pkg;

    localparam int CAM_FRAC = 14;
    localparam logic signed [14:0] CAM_MAX = 15'sd16383;
    localparam logic [23:0] DELTA_ONE = 24'd65536;
    localparam logic [23:0] DELTA_MAX = 24'hFFFFFF;

    localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;
    localparam logic [2:0] REG_DIR_X        = 3'd1;
    localparam logic [2:0] REG_DIR_Y        = 3'd2;
    localparam logic [2:0] REG_PLANE_X      = 3'd3;
    localparam logic [2:0] REG_PLANE_Y      = 3'd4;
    localparam logic [2:0] REG_POS_X        = 3'd5;
    localparam logic [2:0] REG_POS_Y        = 3'd6;

    typedef logic [1:0] t_delta_kind;
    localparam t_delta_kind DK_CALC = 2'd0;
    localparam t_delta_kind DK_ZERO = 2'd1;
    localparam t_delta_kind DK_ONE  = 2'd2;
    localparam t_delta_kind DK_MAX  = 2'd3;

endpackage

// ===== rtl/rcrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// rcrs_div_cell
// One restoring division step: shift in a numerator bit, compare, subtract.
// ----------------------------------------------------------------------------
module rcrs_div_cell #(
    parameter int RW = 13,
    parameter int NW = 1,
    parameter int QW = 15,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [RW-1:0] i_div,
    input  logic [NW-1:0] i_num,
    input  logic [QW-1:0] i_quo,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [RW-1:0] o_rem,
    output logic [RW-1:0] o_div,
    output logic [NW-1:0] o_num,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [RW-1:0] shifted;
    logic          take;
    logic [RW-1:0] n_rem;

    assign shifted = {i_rem[RW-2:0], i_num[NW-1]};
    assign take    = shifted >= i_div;
    assign n_rem   = take ? shifted - i_div : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_div <= i_div;
            o_num <= i_num << 1;
            o_quo <= {i_quo[QW-2:0], take};
            o_pay <= i_pay;
        end
    end

endmodule

// ===== rtl/rcrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rcrs_sqrt_cell
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module rcrs_sqrt_cell #(
    parameter int RW = 25,
    parameter int NW = 50,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [NW-1:0] i_num,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [NW-1:0] o_num,
    output logic [PW-1:0] o_pay
);

    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          take;
    logic [RW+3:0] n_rem;

    assign cur   = {i_rem, i_num[NW-1:NW-2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign take  = cur >= trial;
    assign n_rem = take ? cur - trial : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem[RW+1:0];
            o_root <= {i_root[RW-2:0], take};
            o_num  <= i_num << 2;
            o_pay  <= i_pay;
        end
    end

endmodule

// ===== rtl/raycast_column_ray_setup_core.sv =====
// ----------------------------------------------------------------------------
// raycast_column_ray_setup_core
// Per-column ray setup of a grid raycaster: camera coordinate, ray direction,
// player map cell and the two DDA delta distances.
// ----------------------------------------------------------------------------
// The core takes one column per cycle while the output is not stalled and
// returns one result per column, in order. The transfer edge loads the input
// register. After it come 15 divider cells for the camera coordinate and six
// stages of multiply, add, abs, square and range check. Then come 48 divider
// cells for the squared component ratio, the radicand register, 25 square
// root cells and the output register. When the output is stalled the whole
// cell chain holds and the input stalls with it. Frame registers may only be
// written while no column is in flight.
module raycast_column_ray_setup_core
    import rcrs_pkg::*;
#(
    parameter int COLUMN_BITS = 12,
    parameter int MAP_BITS    = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [23:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COLUMN_BITS-1:0] i_column,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [14:0]     o_camera_coord,
    output logic signed [16:0]     o_ray_dir_x,
    output logic signed [16:0]     o_ray_dir_y,
    output logic [7:0]             o_cell_x,
    output logic [7:0]             o_cell_y,
    output logic [23:0]            o_delta_dist_x,
    output logic [23:0]            o_delta_dist_y
);

    localparam int CMP_W = (COLUMN_BITS > 12) ? COLUMN_BITS : 12;
    localparam logic [7:0] CELL_MASK = 8'((1 << MAP_BITS) - 1);
    localparam int CAM_CELLS = 15;
    localparam int DIV_CELLS = 48;
    localparam int SQ_CELLS  = 25;
    localparam int DRW = 34;
    localparam int SRW = 25;
    localparam int SNW = 50;
    localparam int XPW = 51;

    logic [11:0]        r_screen_width;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [23:0]        r_pos_x, r_pos_y;

    logic en;
    assign en = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= 12'd640;
            r_dir_x        <= -16'sd16384;
            r_dir_y        <= 16'sd0;
            r_plane_x      <= 16'sd0;
            r_plane_y      <= 16'sd10813;
            r_pos_x        <= 24'd98304;
            r_pos_y        <= 24'd98304;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[11:0];
                REG_DIR_X:        r_dir_x        <= i_cfg_data[15:0];
                REG_DIR_Y:        r_dir_y        <= i_cfg_data[15:0];
                REG_PLANE_X:      r_plane_x      <= i_cfg_data[15:0];
                REG_PLANE_Y:      r_plane_y      <= i_cfg_data[15:0];
                REG_POS_X:        r_pos_x        <= i_cfg_data;
                REG_POS_Y:        r_pos_y        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage
    logic                   r_s0_valid;
    logic [COLUMN_BITS-1:0] r_s0_col;
    logic [CMP_W-1:0]       col_ext, w_ext;
    logic                   cam_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_col <= i_column;
        end
    end

    assign col_ext = CMP_W'(r_s0_col);
    assign w_ext   = CMP_W'(r_screen_width);
    assign cam_sat = (r_screen_width == 12'd0) || (col_ext >= w_ext);

    // camera divider chain
    logic        c_valid [0:CAM_CELLS];
    logic [12:0] c_rem   [0:CAM_CELLS];
    logic [12:0] c_div   [0:CAM_CELLS];
    logic [0:0]  c_num   [0:CAM_CELLS];
    logic [14:0] c_quo   [0:CAM_CELLS];
    logic [0:0]  c_pay   [0:CAM_CELLS];

    assign c_valid[0] = r_s0_valid;
    assign c_rem[0]   = {1'b0, col_ext[11:0]};
    assign c_div[0]   = {1'b0, r_screen_width};
    assign c_num[0]   = 1'b0;
    assign c_quo[0]   = '0;
    assign c_pay[0]   = cam_sat;

    for (genvar k = 0; k < CAM_CELLS; k++) begin : g_cam
        rcrs_div_cell #(.RW(13), .NW(1), .QW(15), .PW(1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_div   (c_div[k]),
            .i_num   (c_num[k]),
            .i_quo   (c_quo[k]),
            .i_pay   (c_pay[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_div   (c_div[k+1]),
            .o_num   (c_num[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_pay   (c_pay[k+1])
        );
    end

    // camera, products, ray direction, abs, squares, range check
    logic                r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_s6_valid;
    logic signed [14:0]  r_s1_cam, r_s2_cam, r_s3_cam, r_s4_cam, r_s5_cam, r_s6_cam;
    logic signed [30:0]  r_s2_px, r_s2_py;
    logic signed [16:0]  r_s3_rdx, r_s3_rdy, r_s4_rdx, r_s4_rdy;
    logic signed [16:0]  r_s5_rdx, r_s5_rdy, r_s6_rdx, r_s6_rdy;
    logic [16:0]         r_s4_ax, r_s4_ay;
    logic [33:0]         r_s5_sx, r_s5_sy, r_s6_sx, r_s6_sy;
    t_delta_kind         r_s6_kx, r_s6_ky;
    logic [49:0]         lim_x, lim_y;
    t_delta_kind         kind_x, kind_y;

    assign lim_x = {r_s5_sx, 16'b0} - 50'(r_s5_sx);
    assign lim_y = {r_s5_sy, 16'b0} - 50'(r_s5_sy);

    always_comb begin
        if (r_s5_sy == '0) begin
            kind_x = DK_ZERO;
        end else if (r_s5_sx == '0) begin
            kind_x = DK_ONE;
        end else if (50'(r_s5_sy) >= lim_x) begin
            kind_x = DK_MAX;
        end else begin
            kind_x = DK_CALC;
        end
        if (r_s5_sx == '0) begin
            kind_y = DK_ZERO;
        end else if (r_s5_sy == '0) begin
            kind_y = DK_ONE;
        end else if (50'(r_s5_sx) >= lim_y) begin
            kind_y = DK_MAX;
        end else begin
            kind_y = DK_CALC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= c_valid[CAM_CELLS];
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cam <= c_pay[CAM_CELLS][0] ? CAM_MAX
                      : {~c_quo[CAM_CELLS][14], c_quo[CAM_CELLS][13:0]};
            r_s2_cam <= r_s1_cam;
            r_s2_px  <= r_plane_x * r_s1_cam;
            r_s2_py  <= r_plane_y * r_s1_cam;
            r_s3_cam <= r_s2_cam;
            r_s3_rdx <= {r_dir_x[15], r_dir_x} + 17'(r_s2_px >>> CAM_FRAC);
            r_s3_rdy <= {r_dir_y[15], r_dir_y} + 17'(r_s2_py >>> CAM_FRAC);
            r_s4_cam <= r_s3_cam;
            r_s4_rdx <= r_s3_rdx;
            r_s4_rdy <= r_s3_rdy;
            r_s4_ax  <= r_s3_rdx[16] ? 17'(-r_s3_rdx) : 17'(r_s3_rdx);
            r_s4_ay  <= r_s3_rdy[16] ? 17'(-r_s3_rdy) : 17'(r_s3_rdy);
            r_s5_cam <= r_s4_cam;
            r_s5_rdx <= r_s4_rdx;
            r_s5_rdy <= r_s4_rdy;
            r_s5_sx  <= 34'(r_s4_ax) * 34'(r_s4_ax);
            r_s5_sy  <= 34'(r_s4_ay) * 34'(r_s4_ay);
            r_s6_cam <= r_s5_cam;
            r_s6_rdx <= r_s5_rdx;
            r_s6_rdy <= r_s5_rdy;
            r_s6_sx  <= r_s5_sx;
            r_s6_sy  <= r_s5_sy;
            r_s6_kx  <= kind_x;
            r_s6_ky  <= kind_y;
        end
    end

    // ratio divider chains: floor(other^2 * 2^32 / own^2)
    logic             dx_valid [0:DIV_CELLS];
    logic [DRW-1:0]   dx_rem   [0:DIV_CELLS];
    logic [DRW-1:0]   dx_div   [0:DIV_CELLS];
    logic [47:0]      dx_num   [0:DIV_CELLS];
    logic [47:0]      dx_quo   [0:DIV_CELLS];
    logic [XPW-1:0]   dx_pay   [0:DIV_CELLS];
    logic             dy_valid [0:DIV_CELLS];
    logic [DRW-1:0]   dy_rem   [0:DIV_CELLS];
    logic [DRW-1:0]   dy_div   [0:DIV_CELLS];
    logic [47:0]      dy_num   [0:DIV_CELLS];
    logic [47:0]      dy_quo   [0:DIV_CELLS];
    logic [1:0]       dy_pay   [0:DIV_CELLS];

    assign dx_valid[0] = r_s6_valid;
    assign dx_rem[0]   = DRW'(r_s6_sy[33:16]);
    assign dx_div[0]   = r_s6_sx;
    assign dx_num[0]   = {r_s6_sy[15:0], 32'b0};
    assign dx_quo[0]   = '0;
    assign dx_pay[0]   = {r_s6_cam, r_s6_rdx, r_s6_rdy, r_s6_kx};
    assign dy_valid[0] = r_s6_valid;
    assign dy_rem[0]   = DRW'(r_s6_sx[33:16]);
    assign dy_div[0]   = r_s6_sy;
    assign dy_num[0]   = {r_s6_sx[15:0], 32'b0};
    assign dy_quo[0]   = '0;
    assign dy_pay[0]   = r_s6_ky;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        rcrs_div_cell #(.RW(DRW), .NW(48), .QW(48), .PW(XPW)) u_cell_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dx_valid[k]),
            .i_rem   (dx_rem[k]),
            .i_div   (dx_div[k]),
            .i_num   (dx_num[k]),
            .i_quo   (dx_quo[k]),
            .i_pay   (dx_pay[k]),
            .o_valid (dx_valid[k+1]),
            .o_rem   (dx_rem[k+1]),
            .o_div   (dx_div[k+1]),
            .o_num   (dx_num[k+1]),
            .o_quo   (dx_quo[k+1]),
            .o_pay   (dx_pay[k+1])
        );
        rcrs_div_cell #(.RW(DRW), .NW(48), .QW(48), .PW(2)) u_cell_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dy_valid[k]),
            .i_rem   (dy_rem[k]),
            .i_div   (dy_div[k]),
            .i_num   (dy_num[k]),
            .i_quo   (dy_quo[k]),
            .i_pay   (dy_pay[k]),
            .o_valid (dy_valid[k+1]),
            .o_rem   (dy_rem[k+1]),
            .o_div   (dy_div[k+1]),
            .o_num   (dy_num[k+1]),
            .o_quo   (dy_quo[k+1]),
            .o_pay   (dy_pay[k+1])
        );
    end

    // radicand: 2^32 + ratio
    logic           r_s7_valid;
    logic [SNW-1:0] r_s7_nx, r_s7_ny;
    logic [XPW-1:0] r_s7_pay;
    logic [1:0]     r_s7_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid <= dx_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_nx  <= SNW'(dx_quo[DIV_CELLS]) + (SNW'(1) << 32);
            r_s7_ny  <= SNW'(dy_quo[DIV_CELLS]) + (SNW'(1) << 32);
            r_s7_pay <= dx_pay[DIV_CELLS];
            r_s7_ky  <= dy_pay[DIV_CELLS];
        end
    end

    // square root chains
    logic           qx_valid [0:SQ_CELLS];
    logic [SRW+1:0] qx_rem   [0:SQ_CELLS];
    logic [SRW-1:0] qx_root  [0:SQ_CELLS];
    logic [SNW-1:0] qx_num   [0:SQ_CELLS];
    logic [XPW-1:0] qx_pay   [0:SQ_CELLS];
    logic           qy_valid [0:SQ_CELLS];
    logic [SRW+1:0] qy_rem   [0:SQ_CELLS];
    logic [SRW-1:0] qy_root  [0:SQ_CELLS];
    logic [SNW-1:0] qy_num   [0:SQ_CELLS];
    logic [1:0]     qy_pay   [0:SQ_CELLS];

    assign qx_valid[0] = r_s7_valid;
    assign qx_rem[0]   = '0;
    assign qx_root[0]  = '0;
    assign qx_num[0]   = r_s7_nx;
    assign qx_pay[0]   = r_s7_pay;
    assign qy_valid[0] = r_s7_valid;
    assign qy_rem[0]   = '0;
    assign qy_root[0]  = '0;
    assign qy_num[0]   = r_s7_ny;
    assign qy_pay[0]   = r_s7_ky;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        rcrs_sqrt_cell #(.RW(SRW), .NW(SNW), .PW(XPW)) u_cell_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (qx_valid[k]),
            .i_rem   (qx_rem[k]),
            .i_root  (qx_root[k]),
            .i_num   (qx_num[k]),
            .i_pay   (qx_pay[k]),
            .o_valid (qx_valid[k+1]),
            .o_rem   (qx_rem[k+1]),
            .o_root  (qx_root[k+1]),
            .o_num   (qx_num[k+1]),
            .o_pay   (qx_pay[k+1])
        );
        rcrs_sqrt_cell #(.RW(SRW), .NW(SNW), .PW(2)) u_cell_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (qy_valid[k]),
            .i_rem   (qy_rem[k]),
            .i_root  (qy_root[k]),
            .i_num   (qy_num[k]),
            .i_pay   (qy_pay[k]),
            .o_valid (qy_valid[k+1]),
            .o_rem   (qy_rem[k+1]),
            .o_root  (qy_root[k+1]),
            .o_num   (qy_num[k+1]),
            .o_pay   (qy_pay[k+1])
        );
    end

    // output register
    t_delta_kind    fin_kx, fin_ky;
    logic [SRW-1:0] fin_rx, fin_ry;
    logic [23:0]    dist_x, dist_y;

    assign fin_kx = qx_pay[SQ_CELLS][1:0];
    assign fin_ky = qy_pay[SQ_CELLS];
    assign fin_rx = qx_root[SQ_CELLS];
    assign fin_ry = qy_root[SQ_CELLS];

    always_comb begin
        case (fin_kx)
            DK_ZERO: dist_x = '0;
            DK_ONE:  dist_x = DELTA_ONE;
            DK_MAX:  dist_x = DELTA_MAX;
            default: dist_x = fin_rx[24] ? DELTA_MAX : fin_rx[23:0];
        endcase
        case (fin_ky)
            DK_ZERO: dist_y = '0;
            DK_ONE:  dist_y = DELTA_ONE;
            DK_MAX:  dist_y = DELTA_MAX;
            default: dist_y = fin_ry[24] ? DELTA_MAX : fin_ry[23:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= qx_valid[SQ_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_camera_coord <= qx_pay[SQ_CELLS][50:36];
            o_ray_dir_x    <= qx_pay[SQ_CELLS][35:19];
            o_ray_dir_y    <= qx_pay[SQ_CELLS][18:2];
            o_cell_x       <= r_pos_x[23:16] & CELL_MASK;
            o_cell_y       <= r_pos_y[23:16] & CELL_MASK;
            o_delta_dist_x <= dist_x;
            o_delta_dist_y <= dist_y;
        end
    end

endmodule

// ===== rtl/rcrs_checker.sv =====
// ----------------------------------------------------------------------------
// rcrs_checker
// Port-level checks of the column ray setup core, bound to the top level.
// ----------------------------------------------------------------------------
module rcrs_checker
    import rcrs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [14:0] o_camera_coord,
    input logic signed [16:0] o_ray_dir_x,
    input logic signed [16:0] o_ray_dir_y,
    input logic [23:0]        o_delta_dist_x,
    input logic [23:0]        o_delta_dist_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_camera_coord)
            && $stable(o_ray_dir_x) && $stable(o_delta_dist_x))
        else $error("stalled result changed");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_zero_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ray_dir_y == 17'sd0 |-> o_delta_dist_x == 24'd0)
        else $error("delta x not zero for zero y component");

    a_zero_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ray_dir_y == 17'sd0 && o_ray_dir_x != 17'sd0
            |-> o_delta_dist_y == DELTA_ONE)
        else $error("delta y not one for zero own component");

endmodule

bind raycast_column_ray_setup_core rcrs_checker u_rcrs_checker (.*);
